// File: design/gcbc_pkg.sv
// Shared constants for the grid connected block counter.
// Used by the top level; no dependencies.
`default_nettype none

package gcbc_pkg;

	// Default side length of the largest grid the block can hold
	localparam int GRID_DIM_DEF = 64;

	// Configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

	// Size register reset value, before clamping to the grid limit
	localparam int SIZE_RESET = 64;

	// Result count
	localparam int COUNT_W = 12;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

endpackage

`default_nettype wire

// File: design/gcbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module gcbc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/grid_connected_block_count_top.sv
// Operation: one cell per cycle while loading; after the last cell the search reads each scanned
//   cell, checks each block's queue until it is empty, reads each dequeued cell and tests each of
//   its four neighbor directions, then ends the scan and posts the count.
// Throughput: no cell is taken during the search or while a new count waits to be posted.
// Reset: control state and size registers reset asynchronously; RAM contents are not
//   cleared, every cell used by a search is written during its own load.
`default_nettype none

module grid_connected_block_count_top #(
	parameter int GRID_DIM = gcbc_pkg::GRID_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gcbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cell_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gcbc_pkg::COUNT_W-1:0]   block_count
);

	import gcbc_pkg::*;

	localparam int CELLS = GRID_DIM * GRID_DIM;
	localparam int IW    = $clog2(CELLS);
	localparam int TW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(GRID_DIM);
	localparam int DW    = $clog2(GRID_DIM + 1);
	localparam int SW    = (DW > CFG_W) ? DW : CFG_W;
	localparam int QW    = 2 * CW + IW;
	localparam logic [DW-1:0] DIM_RESET =
		(GRID_DIM < SIZE_RESET) ? DW'(GRID_DIM) : DW'(SIZE_RESET);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DEQ_RD,
		ST_DEQ_WAIT,
		ST_NB_RD,
		ST_NB_CHK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIR_RIGHT,
		DIR_LEFT,
		DIR_DOWN,
		DIR_UP
	} dir_t;

	function automatic logic [DW-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [SW-1:0] w;
		w = SW'(v);
		if (w == '0) begin
			return DW'(1);
		end else if (w > SW'(GRID_DIM)) begin
			return DW'(GRID_DIM);
		end else begin
			return DW'(w);
		end
	endfunction

	state_t             state_q;
	dir_t               dir_q;
	logic [DW-1:0]      rows_q, cols_q;
	logic [DW-1:0]      srows_q, scols_q;
	logic [TW-1:0]      stotal_q;
	logic [IW-1:0]      load_pos_q;
	logic [TW-1:0]      scan_i_q;
	logic [CW-1:0]      scan_r_q, scan_c_q;
	logic [TW-1:0]      head_q, tail_q;
	logic [CW-1:0]      cur_r_q, cur_c_q;
	logic [IW-1:0]      cur_idx_q;
	logic [CW-1:0]      nb_r_q, nb_c_q;
	logic [IW-1:0]      nb_idx_q;
	logic [COUNT_W-1:0] tally_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;

	logic [TW-1:0]      total_live;
	logic [TW-1:0]      lp_next;
	logic               load_last;

	logic               nb_ok;
	logic [CW-1:0]      nb_r, nb_c;
	logic [IW-1:0]      nb_idx;

	logic               grid_we;
	logic [IW-1:0]      grid_waddr, grid_raddr;
	logic [0:0]         grid_wdata, grid_rd;
	logic               q_we;
	logic [IW-1:0]      q_waddr, q_raddr;
	logic [QW-1:0]      q_wdata, q_rd;

	assign total_live = TW'(rows_q) * TW'(cols_q);
	assign lp_next    = TW'(load_pos_q) + TW'(1);
	assign load_last  = (lp_next >= total_live);

	assign in_stall    = (state_q != ST_LOAD);
	assign out_valid   = out_valid_q;
	assign block_count = count_q;

	// Neighbor of the current cell in the direction under test
	always_comb begin
		nb_ok  = 1'b0;
		nb_r   = cur_r_q;
		nb_c   = cur_c_q;
		nb_idx = cur_idx_q;
		case (dir_q)
			DIR_RIGHT: begin
				nb_ok  = (DW'(cur_c_q) + DW'(1)) < scols_q;
				nb_c   = cur_c_q + CW'(1);
				nb_idx = cur_idx_q + IW'(1);
			end
			DIR_LEFT: begin
				nb_ok  = (cur_c_q != '0);
				nb_c   = cur_c_q - CW'(1);
				nb_idx = cur_idx_q - IW'(1);
			end
			DIR_DOWN: begin
				nb_ok  = (DW'(cur_r_q) + DW'(1)) < srows_q;
				nb_r   = cur_r_q + CW'(1);
				nb_idx = cur_idx_q + IW'(scols_q);
			end
			DIR_UP: begin
				nb_ok  = (cur_r_q != '0);
				nb_r   = cur_r_q - CW'(1);
				nb_idx = cur_idx_q - IW'(scols_q);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// RAM port steering; a visited cell is marked by clearing its grid bit
	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = load_pos_q;
		grid_wdata = 1'b0;
		grid_raddr = '0;
		q_we       = 1'b0;
		q_waddr    = tail_q[IW-1:0];
		q_wdata    = {nb_r_q, nb_c_q, nb_idx_q};
		q_raddr    = head_q[IW-1:0];
		case (state_q)
			ST_LOAD: begin
				grid_we    = in_valid;
				grid_wdata = cell_req;
			end
			ST_SCAN_RD: begin
				grid_raddr = scan_i_q[IW-1:0];
			end
			ST_SCAN_CHK: begin
				grid_we    = grid_rd[0];
				grid_waddr = scan_i_q[IW-1:0];
				q_we       = grid_rd[0];
				q_waddr    = '0;
				q_wdata    = {scan_r_q, scan_c_q, scan_i_q[IW-1:0]};
			end
			ST_NB_RD: begin
				grid_raddr = nb_idx;
			end
			ST_NB_CHK: begin
				grid_we    = grid_rd[0];
				grid_waddr = nb_idx_q;
				q_we       = grid_rd[0];
			end
			default: begin
				grid_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			dir_q       <= DIR_RIGHT;
			rows_q      <= DIM_RESET;
			cols_q      <= DIM_RESET;
			srows_q     <= DIM_RESET;
			scols_q     <= DIM_RESET;
			stotal_q    <= '0;
			load_pos_q  <= '0;
			scan_i_q    <= '0;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cur_r_q     <= '0;
			cur_c_q     <= '0;
			cur_idx_q   <= '0;
			nb_r_q      <= '0;
			nb_c_q      <= '0;
			nb_idx_q    <= '0;
			tally_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: rows_q <= clamp_size(cfg_data);
					REG_COLS: cols_q <= clamp_size(cfg_data);
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (load_last) begin
							load_pos_q <= '0;
							srows_q    <= rows_q;
							scols_q    <= cols_q;
							stotal_q   <= total_live;
							scan_i_q   <= '0;
							scan_r_q   <= '0;
							scan_c_q   <= '0;
							tally_q    <= '0;
							state_q    <= ST_SCAN_RD;
						end else begin
							load_pos_q <= lp_next[IW-1:0];
						end
					end
				end
				ST_SCAN_RD: begin
					if (scan_i_q == stotal_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN_CHK;
					end
				end
				ST_SCAN_CHK: begin
					scan_i_q <= scan_i_q + TW'(1);
					if ((DW'(scan_c_q) + DW'(1)) == scols_q) begin
						scan_c_q <= '0;
						scan_r_q <= scan_r_q + CW'(1);
					end else begin
						scan_c_q <= scan_c_q + CW'(1);
					end
					if (grid_rd[0]) begin
						// new block: seed the queue with this cell
						if (tally_q != COUNT_MAX) begin
							tally_q <= tally_q + COUNT_W'(1);
						end
						head_q  <= '0;
						tail_q  <= TW'(1);
						state_q <= ST_DEQ_RD;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_DEQ_RD: begin
					if (head_q == tail_q) begin
						state_q <= ST_SCAN_RD;
					end else begin
						head_q  <= head_q + TW'(1);
						state_q <= ST_DEQ_WAIT;
					end
				end
				ST_DEQ_WAIT: begin
					{cur_r_q, cur_c_q, cur_idx_q} <= q_rd;
					dir_q   <= DIR_RIGHT;
					state_q <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (nb_ok) begin
						nb_r_q   <= nb_r;
						nb_c_q   <= nb_c;
						nb_idx_q <= nb_idx;
						state_q  <= ST_NB_CHK;
					end else if (dir_q == DIR_UP) begin
						state_q <= ST_DEQ_RD;
					end else begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				ST_NB_CHK: begin
					if (grid_rd[0]) begin
						tail_q <= tail_q + TW'(1);
					end
					if (dir_q == DIR_UP) begin
						state_q <= ST_DEQ_RD;
					end else begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= ST_NB_RD;
					end
				end
				ST_DONE: begin
					// hold until the result register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						count_q     <= tally_q;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	gcbc_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_grid_ram (
		.clk  (clk),
		.we   (grid_we),
		.waddr(grid_waddr),
		.wdata(grid_wdata),
		.raddr(grid_raddr),
		.rdata(grid_rd)
	);

	gcbc_ram #(
		.WIDTH(QW),
		.DEPTH(CELLS)
	) u_queue_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(q_raddr),
		.rdata(q_rd)
	);

endmodule

`default_nettype wire

// File: dv/gcbc_count_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the grid connected block counter: follows the size registers and the
// loaded cells, predicts each block count with its own flood fill and compares results.
// Depends on gcbc_pkg for register indexes, widths and the count ceiling.
module gcbc_count_checker #(
	parameter int GRID_DIM = gcbc_pkg::GRID_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gcbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcbc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           cell_req,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [gcbc_pkg::COUNT_W-1:0]   block_count,
	output int                             counts_waiting,
	output int                             errors
);
	import gcbc_pkg::*;

	localparam int CELLS = GRID_DIM * GRID_DIM;
	localparam int ROW_STEP [4] = '{0, 0, 1, -1};
	localparam int COL_STEP [4] = '{1, -1, 0, 0};

	logic [CFG_W-1:0]   rows_reg;
	logic [CFG_W-1:0]   cols_reg;
	bit                 grid_bits [CELLS];
	int                 load_pos;
	int                 grid_cells;
	logic [COUNT_W-1:0] counts_q [$];
	logic [COUNT_W-1:0] want;

	function automatic int fit_dim(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > GRID_DIM) return GRID_DIM;
		return int'(v);
	endfunction

	// Scan in raster order and flood each unseen filled cell breadth first
	function automatic logic [COUNT_W-1:0] count_blocks_bfs(int rows, int cols);
		bit seen [CELLS];
		int frontier [$];
		int n;
		int cur;
		int nr;
		int nc;
		int nxt;
		n = 0;
		for (int i = 0; i < rows * cols; i++) begin
			if (grid_bits[i] && !seen[i]) begin
				if (n < COUNT_MAX) n++;
				seen[i] = 1'b1;
				frontier.push_back(i);
				while (frontier.size() != 0) begin
					cur = frontier.pop_front();
					for (int k = 0; k < 4; k++) begin
						nr = cur / cols + ROW_STEP[k];
						nc = cur % cols + COL_STEP[k];
						if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
							nxt = nr * cols + nc;
							if (grid_bits[nxt] && !seen[nxt]) begin
								seen[nxt] = 1'b1;
								frontier.push_back(nxt);
							end
						end
					end
				end
			end
		end
		return n[COUNT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = CFG_W'(SIZE_RESET);
			cols_reg = CFG_W'(SIZE_RESET);
			load_pos = 0;
			counts_q.delete();
			errors = 0;
			counts_waiting <= 0;
		end else begin
			if (cfg_we === 1'b1) begin
				if (cfg_index == REG_ROWS) rows_reg = cfg_data;
				else if (cfg_index == REG_COLS) cols_reg = cfg_data;
			end
			// size is read again on every transaction, so a mid-load change takes effect
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				grid_cells = fit_dim(rows_reg) * fit_dim(cols_reg);
				grid_bits[load_pos] = cell_req;
				load_pos++;
				if (load_pos >= grid_cells) begin
					counts_q.push_back(count_blocks_bfs(fit_dim(rows_reg), fit_dim(cols_reg)));
					load_pos = 0;
				end
			end
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (counts_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected block_count %0d, no grid pending", block_count);
				end else begin
					want = counts_q.pop_front();
					if (block_count !== want) begin
						errors++;
						if (errors <= 10)
							$display("block_count mismatch: expected %0d actual %0d",
								want, block_count);
					end
				end
			end
			counts_waiting <= counts_q.size();
		end
	end

endmodule

// File: dv/tb_grid_connected_block_count_top.sv
`timescale 1ns / 1ps
// Testbench top for grid_connected_block_count_top: drives sizes and cell streams,
// stalls the result side, and gives the verdict from gcbc_count_checker.
// Depends on gcbc_pkg, the block and dv/gcbc_count_checker.sv.
module tb_grid_connected_block_count_top;
	import gcbc_pkg::*;

	localparam int GRID = GRID_DIM_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int CELL_TARGET   = 1425;
	localparam int QUIET_TAIL    = 200;
	localparam int PRESSURE_AT   = 400;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_LIMIT     = 200000;
	localparam int TIMEOUT_NS    = 5_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic cell_req;
	logic out_valid;
	logic out_stall;
	logic [COUNT_W-1:0] block_count;
	int counts_waiting;
	int errors;

	logic [CFG_W-1:0] rows_val;
	logic [CFG_W-1:0] cols_val;
	int load_pos;
	int cells_sent;
	int gap_pct;
	bit quiet;
	bit hold_long;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	grid_connected_block_count_top #(.GRID_DIM(GRID)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_req   (cell_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.block_count(block_count)
	);

	gcbc_count_checker #(.GRID_DIM(GRID)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cell_req      (cell_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_count   (block_count),
		.counts_waiting(counts_waiting),
		.errors        (errors)
	);

	function automatic int fit_dim(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > GRID) return GRID;
		return int'(v);
	endfunction

	function automatic int grid_total();
		return fit_dim(rows_val) * fit_dim(cols_val);
	endfunction

	function automatic int pick_density();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 10;
			2: return 30;
			3: return 50;
			4: return 70;
			5: return 90;
			default: return 100;
		endcase
	endfunction

	task automatic put_cell(input logic v);
		if (gap_pct != 0 && !quiet && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_req <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		cells_sent++;
		load_pos++;
		if (load_pos >= grid_total()) load_pos = 0;
	endtask

	task automatic load_cells(input int n, input int pct);
		for (int i = 0; i < n; i++) put_cell($urandom_range(1, 100) <= pct);
	endtask

	// After a shrink below the cells already loaded, one more cell completes the grid
	task automatic finish_grid(input int pct);
		load_cells((load_pos < grid_total()) ? grid_total() - load_pos : 1, pct);
	endtask

	// Wait for every pending count, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (counts_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS) rows_val = val;
		else if (idx == REG_COLS) cols_val = val;
		@(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		drain();
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
	endtask

	// Result side: random stall bursts, one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_long) begin
				hold_long = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] rv;
		logic [CFG_W-1:0] cv;
		int sel;
		int ngrids;
		int guard;
		bit pressed;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cell_req <= 1'b0;
		rows_val = CFG_W'(SIZE_RESET);
		cols_val = CFG_W'(SIZE_RESET);
		load_pos = 0;
		cells_sent = 0;
		gap_pct = 0;
		quiet = 1'b0;
		hold_long = 1'b0;
		pressed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sizes act as one: single-cell grids
		set_size(7'd0, 7'd0);
		put_cell(1'b1);
		put_cell(1'b0);
		// writes to unused indexes must leave the sizes alone
		drain();
		write_reg(REG_SPARE_LO, 7'h7F);
		write_reg(REG_SPARE_HI, 7'h2A);
		set_size(7'd1, 7'd2);
		put_cell(1'b1);
		put_cell(1'b1);
		// diagonal cells do not connect
		set_size(7'd2, 7'd2);
		put_cell(1'b1);
		put_cell(1'b0);
		put_cell(1'b0);
		put_cell(1'b1);
		set_size(7'd2, 7'd3);
		load_cells(6, 100);
		set_size(7'd3, 7'd1);
		put_cell(1'b1);
		put_cell(1'b0);
		put_cell(1'b1);
		// shrink the grid mid-load so the next cell completes it
		set_size(7'd3, 7'd3);
		put_cell(1'b1);
		put_cell(1'b1);
		put_cell(1'b0);
		put_cell(1'b1);
		put_cell(1'b0);
		drain();
		write_reg(REG_COLS, 7'd1);
		put_cell(1'b1);

		// sizes above the grid limit clamp to it
		set_size(7'h7F, 7'd1);
		finish_grid(pick_density());
		set_size(7'd0, 7'd100);
		finish_grid(pick_density());

		while (cells_sent < CELL_TARGET) begin
			quiet = (cells_sent >= CELL_TARGET - QUIET_TAIL);
			case ($urandom_range(0, 3))
				0, 1: gap_pct = 0;
				2: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			if (!pressed && cells_sent >= PRESSURE_AT) begin
				// back up the result side while cells keep coming
				pressed = 1'b1;
				gap_pct = 0;
				set_size(7'd2, 7'd2);
				hold_long = 1'b1;
				repeat (12) finish_grid(50);
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					rv = CFG_W'($urandom_range(0, 8));
					cv = CFG_W'($urandom_range(0, 8));
				end else if (sel < 8) begin
					rv = CFG_W'($urandom_range(9, 127));
					cv = CFG_W'($urandom_range(0, 3));
					if ($urandom_range(0, 1)) {rv, cv} = {cv, rv};
				end else begin
					rv = CFG_W'($urandom_range(5, 16));
					cv = CFG_W'($urandom_range(5, 16));
				end
				set_size(rv, cv);
				if ($urandom_range(0, 9) == 0)
					write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
						CFG_W'($urandom_range(0, 127)));
				ngrids = $urandom_range(1, 3);
				for (int g = 0; g < ngrids; g++) begin
					if (cells_sent >= CELL_TARGET) break;
					if (g == 0 && grid_total() > 1 && $urandom_range(0, 7) == 0) begin
						load_cells($urandom_range(1, grid_total() - 1), pick_density());
						drain();
						write_reg($urandom_range(0, 1) ? REG_ROWS : REG_COLS,
							CFG_W'($urandom_range(0, 9)));
					end
					finish_grid(pick_density());
				end
			end
		end

		quiet = 1'b1;
		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (counts_waiting != 0 && guard < END_LIMIT);
		repeat (20) @(posedge clk);
		if (errors == 0 && counts_waiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
design/gcbc_pkg.sv
design/gcbc_ram.sv
design/grid_connected_block_count_top.sv
dv/gcbc_count_checker.sv
dv/tb_grid_connected_block_count_top.sv
